// File: rtl/ddm_pkg.sv
// Shared constants and types of the differential drive mixer.
// No dependencies; imported by ddm_divider and differential_drive_mixer_top.
package ddm_pkg;

    localparam int DUTY_BITS = 16;
    localparam int A_W       = 10;
    localparam int G_W       = 11;
    localparam int PROD_W    = 27;
    localparam int NUM_W     = 38;
    localparam int MAG_W     = 33;
    localparam int DIV_W     = 16;
    localparam int DIV_STEPS = MAG_W;
    localparam int PIPE_DEPTH = 4 + DIV_STEPS + 1;
    localparam int ADDR_W    = 4;

    localparam logic [MAG_W-1:0] DUTY_FULL = MAG_W'((64'd1 << DUTY_BITS) - 64'd1);

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [7:0]  CENTER_RESET = 8'd127;

    localparam logic MODE_TANK = 1'b0;
    localparam logic MODE_CAR  = 1'b1;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_CENTER = 2'd1,
        REG_MODE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [A_W-1:0] a_left;
        logic signed [A_W-1:0] a_right;
        logic signed [G_W-1:0] g_left;
        logic signed [G_W-1:0] g_right;
        logic [DIV_W-1:0]      divisor;
    } front_t;

endpackage

// File: rtl/ddm_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ddm_pkg for the dividend, divisor and step count widths.
module ddm_divider import ddm_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag_in,
    input  logic [DIV_W-1:0] div_in,
    input  logic             pos_in,
    output logic [MAG_W-1:0] quot_out,
    output logic             pos_out
);

    logic [DIV_W-1:0] rem_reg [DIV_STEPS];
    logic [MAG_W-1:0] dq_reg  [DIV_STEPS];
    logic [DIV_W-1:0] div_reg [DIV_STEPS];
    logic             pos_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_W-1:0] rem_prev;
        logic [DIV_W-1:0] div_prev;
        logic [MAG_W-1:0] dq_prev;
        logic             pos_prev;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        logic             q_bit;
        logic [DIV_W-1:0] rem_next;
        logic [MAG_W-1:0] dq_next;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign div_prev = div_in;
            assign dq_prev  = mag_in;
            assign pos_prev = pos_in;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign div_prev = div_reg[k-1];
            assign dq_prev  = dq_reg[k-1];
            assign pos_prev = pos_reg[k-1];
        end

        // The dividend shifts out at the top while quotient bits shift in below.
        always_comb begin
            trial    = {rem_prev, dq_prev[MAG_W-1]};
            diff     = trial - {1'b0, div_prev};
            q_bit    = (trial >= {1'b0, div_prev});
            rem_next = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dq_next  = {dq_prev[MAG_W-2:0], q_bit};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                dq_reg[k]  <= dq_next;
                div_reg[k] <= div_prev;
                pos_reg[k] <= pos_prev;
            end
        end
    end

    assign quot_out = dq_reg[DIV_STEPS-1];
    assign pos_out  = pos_reg[DIV_STEPS-1];

endmodule

// File: rtl/differential_drive_mixer_top.sv
// Top level of the differential drive mixer: skid stage, mixing multipliers,
// two dividers and the clamp stage. Depends on ddm_pkg and ddm_divider.
//
// The mixer takes one stick transfer per clock while the output is not stalled and
// returns one result transfer for each, in order. The pipeline has 38 register
// stages: the mixing-factor stage, two multiply stages, the magnitude stage, the
// 33 one-bit steps of the restoring dividers and the clamp stage. The whole
// pipeline holds while a result waits at the output, and a one-entry skid stage
// still takes one more input transfer during such a stall.
// Registers are at byte addresses 0 (period), 4 (center) and 8 (mode) and should
// be written only while the pipeline is empty.
module differential_drive_mixer_top import ddm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_speed_stick,
    input  logic [7:0]        s_steer_stick,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_left_forward,
    output logic [15:0]       m_left_duty,
    output logic              m_right_forward,
    output logic [15:0]       m_right_duty,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] pwm_period_reg;
    logic [7:0]  stick_center_reg;
    logic        drive_mode_reg;

    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [7:0]  skid_speed_reg;
    logic [7:0]  skid_steer_reg;

    logic        valid_reg [PIPE_DEPTH];
    logic        en;
    logic        accept;
    logic        src_valid;
    logic [7:0]  src_speed;
    logic [7:0]  src_steer;

    logic [7:0]  c_eff;
    logic [8:0]  s_val;
    logic [8:0]  d_val;
    logic        d_pos;
    logic signed [A_W-1:0] s_ext;
    logic signed [A_W-1:0] d_ext;
    logic signed [G_W-1:0] c_g;
    logic signed [G_W-1:0] d_g;
    front_t      front_next;
    front_t      front_reg;

    logic signed [PROD_W-1:0] prod_l_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic signed [G_W-1:0]    g_l1_reg;
    logic signed [G_W-1:0]    g_r1_reg;
    logic [DIV_W-1:0]         div1_reg;

    logic signed [NUM_W-1:0]  num_l_reg;
    logic signed [NUM_W-1:0]  num_r_reg;
    logic [DIV_W-1:0]         div2_reg;

    logic [NUM_W-1:0]         abs_l;
    logic [NUM_W-1:0]         abs_r;
    logic [MAG_W-1:0]         mag_l_reg;
    logic [MAG_W-1:0]         mag_r_reg;
    logic                     pos_l_reg;
    logic                     pos_r_reg;
    logic [DIV_W-1:0]         div3_reg;

    logic [MAG_W-1:0]         quot_l;
    logic [MAG_W-1:0]         quot_r;
    logic                     pos_l_q;
    logic                     pos_r_q;
    logic [MAG_W-1:0]         lim;
    logic [MAG_W-1:0]         duty_l;
    logic [MAG_W-1:0]         duty_r;

    logic                     left_forward_reg;
    logic                     right_forward_reg;
    logic [15:0]              left_duty_reg;
    logic [15:0]              right_duty_reg;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg   <= PERIOD_RESET;
            stick_center_reg <= CENTER_RESET;
            drive_mode_reg   <= MODE_TANK;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx_t'(paddr[ADDR_W-1:2]))
                REG_PERIOD: pwm_period_reg   <= pwdata[15:0];
                REG_CENTER: stick_center_reg <= pwdata[7:0];
                REG_MODE:   drive_mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_PERIOD: prdata = {16'b0, pwm_period_reg};
            REG_CENTER: prdata = {24'b0, stick_center_reg};
            REG_MODE:   prdata = {31'b0, drive_mode_reg};
            default:    prdata = '0;
        endcase
    end

    // Input skid stage and pipeline enable.
    assign en        = !valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign src_valid = skid_valid_reg || s_valid;
    assign src_speed = skid_valid_reg ? skid_speed_reg : s_speed_stick;
    assign src_steer = skid_valid_reg ? skid_steer_reg : s_steer_stick;

    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg || accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && accept) begin
            skid_speed_reg <= s_speed_stick;
            skid_steer_reg <= s_steer_stick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= src_valid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Stage 0: centered sticks and mixing factors. In car mode both sides share
    // the divisor center squared, so the plain side is multiplied by the center.
    always_comb begin
        c_eff = (stick_center_reg == 8'd0) ? 8'd1 : stick_center_reg;
        s_val = {1'b0, src_speed} - {1'b0, c_eff};
        d_val = {1'b0, src_steer} - {1'b0, c_eff};
        d_pos = !d_val[8] && (d_val != 9'd0);
        s_ext = {s_val[8], s_val};
        d_ext = {d_val[8], d_val};
        c_g   = {3'b0, c_eff};
        d_g   = {{2{d_val[8]}}, d_val};
        case (drive_mode_reg)
            MODE_TANK: begin
                front_next.a_left  = s_ext + d_ext;
                front_next.a_right = s_ext - d_ext;
                front_next.g_left  = G_W'(1);
                front_next.g_right = G_W'(1);
                front_next.divisor = {8'b0, c_eff};
            end
            MODE_CAR: begin
                front_next.a_left  = s_ext;
                front_next.a_right = s_ext;
                front_next.g_left  = d_pos ? c_g : c_g + d_g;
                front_next.g_right = d_pos ? c_g - d_g : c_g;
                front_next.divisor = DIV_W'(c_eff) * DIV_W'(c_eff);
            end
            default: begin
                front_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    // Stage 1: multiply by the period.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_l_reg <= front_reg.a_left * $signed({1'b0, pwm_period_reg});
            prod_r_reg <= front_reg.a_right * $signed({1'b0, pwm_period_reg});
            g_l1_reg   <= front_reg.g_left;
            g_r1_reg   <= front_reg.g_right;
            div1_reg   <= front_reg.divisor;
        end
    end

    // Stage 2: multiply by the steering factor.
    always_ff @(posedge aclk) begin
        if (en) begin
            num_l_reg <= prod_l_reg * g_l1_reg;
            num_r_reg <= prod_r_reg * g_r1_reg;
            div2_reg  <= div1_reg;
        end
    end

    // Stage 3: sign and magnitude.
    always_comb begin
        abs_l = num_l_reg[NUM_W-1] ? NUM_W'(-num_l_reg) : NUM_W'(num_l_reg);
        abs_r = num_r_reg[NUM_W-1] ? NUM_W'(-num_r_reg) : NUM_W'(num_r_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_l_reg <= abs_l[MAG_W-1:0];
            mag_r_reg <= abs_r[MAG_W-1:0];
            pos_l_reg <= !num_l_reg[NUM_W-1] && (num_l_reg != '0);
            pos_r_reg <= !num_r_reg[NUM_W-1] && (num_r_reg != '0);
            div3_reg  <= div2_reg;
        end
    end

    ddm_divider u_div_left (
        .aclk     (aclk),
        .en       (en),
        .mag_in   (mag_l_reg),
        .div_in   (div3_reg),
        .pos_in   (pos_l_reg),
        .quot_out (quot_l),
        .pos_out  (pos_l_q)
    );

    ddm_divider u_div_right (
        .aclk     (aclk),
        .en       (en),
        .mag_in   (mag_r_reg),
        .div_in   (div3_reg),
        .pos_in   (pos_r_reg),
        .quot_out (quot_r),
        .pos_out  (pos_r_q)
    );

    // Output stage: clamp to the period and to the duty full scale.
    always_comb begin
        lim    = (MAG_W'(pwm_period_reg) > DUTY_FULL) ? DUTY_FULL : MAG_W'(pwm_period_reg);
        duty_l = (quot_l > lim) ? lim : quot_l;
        duty_r = (quot_r > lim) ? lim : quot_r;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            left_forward_reg  <= pos_l_q && (quot_l != '0);
            right_forward_reg <= pos_r_q && (quot_r != '0);
            left_duty_reg     <= duty_l[15:0];
            right_duty_reg    <= duty_r[15:0];
        end
    end

    assign m_valid         = valid_reg[PIPE_DEPTH-1];
    assign m_left_forward  = left_forward_reg;
    assign m_left_duty     = left_duty_reg;
    assign m_right_forward = right_forward_reg;
    assign m_right_duty    = right_duty_reg;

endmodule
